// ----- hdl/spo_pkg.sv -----
package spo_pkg;

  // Default coordinate width; sizes and radii are one bit narrower.
  localparam int COORD_BITS_DEF = 16;

  localparam int OP_BITS = 3;

  // Pair kinds. Codes 5 to 7 carry no meaning and never report an overlap.
  typedef enum logic [OP_BITS-1:0] {
    OP_CIRCLE_CIRCLE = 3'd0,
    OP_BOX_BOX       = 3'd1,
    OP_CIRCLE_BOX    = 3'd2,
    OP_CIRCLE_POINT  = 3'd3,
    OP_BOX_POINT     = 3'd4
  } op_e;

  // Outcomes of the compare-only tests, settled in the first stage.
  typedef struct packed {
    logic box_box;     // strict interval overlap of two boxes
    logic box_point;   // half-open containment of the point
    logic cb_pretest;  // circle bounding box overlaps the box
    logic cb_other;    // centre in box or projecting onto an edge span
  } hit_flags_t;

endpackage

// ----- hdl/spo_in_if.sv -----
interface spo_in_if #(
  parameter int COORD_BITS = spo_pkg::COORD_BITS_DEF
) ();
  logic                                valid;
  logic                                ready;
  logic [spo_pkg::OP_BITS-1:0]         op;
  logic signed [COORD_BITS-1:0]        first_x;
  logic signed [COORD_BITS-1:0]        first_y;
  logic [COORD_BITS-2:0]               first_width;
  logic [COORD_BITS-2:0]               first_height;
  logic [COORD_BITS-2:0]               first_radius;
  logic signed [COORD_BITS-1:0]        second_x;
  logic signed [COORD_BITS-1:0]        second_y;
  logic [COORD_BITS-2:0]               second_width;
  logic [COORD_BITS-2:0]               second_height;
  logic [COORD_BITS-2:0]               second_radius;

  modport source (
    output valid, op, first_x, first_y, first_width, first_height, first_radius,
           second_x, second_y, second_width, second_height, second_radius,
    input  ready
  );

  modport sink (
    input  valid, op, first_x, first_y, first_width, first_height, first_radius,
           second_x, second_y, second_width, second_height, second_radius,
    output ready
  );
endinterface

// ----- hdl/spo_out_if.sv -----
interface spo_out_if ();
  logic valid;
  logic ready;
  logic overlapping;

  modport source (
    output valid, overlapping,
    input  ready
  );

  modport sink (
    input  valid, overlapping,
    output ready
  );
endinterface

// ----- hdl/spo_prep.sv -----
module spo_prep #(
  parameter int COORD_BITS = spo_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [spo_pkg::OP_BITS-1:0]  op_i,
  input  logic signed [COORD_BITS-1:0] first_x_i,
  input  logic signed [COORD_BITS-1:0] first_y_i,
  input  logic [COORD_BITS-2:0]        first_width_i,
  input  logic [COORD_BITS-2:0]        first_height_i,
  input  logic [COORD_BITS-2:0]        first_radius_i,
  input  logic signed [COORD_BITS-1:0] second_x_i,
  input  logic signed [COORD_BITS-1:0] second_y_i,
  input  logic [COORD_BITS-2:0]        second_width_i,
  input  logic [COORD_BITS-2:0]        second_height_i,
  input  logic [COORD_BITS-2:0]        second_radius_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [spo_pkg::OP_BITS-1:0]  op_o,
  output logic [COORD_BITS:0]          mag_xl_o,
  output logic [COORD_BITS:0]          mag_xr_o,
  output logic [COORD_BITS:0]          mag_yt_o,
  output logic [COORD_BITS:0]          mag_yb_o,
  output logic [COORD_BITS-1:0]        radius_o,
  output spo_pkg::hit_flags_t          flags_o
);
  import spo_pkg::*;

  // Extended width: holds every sum and difference of a coordinate and sizes.
  localparam int EW = COORD_BITS + 2;
  localparam int MW = COORD_BITS + 1;

  logic signed [EW-1:0] x1, y1, w1, h1, r1, x2, y2, w2, h2;
  logic signed [EW-1:0] dxl, dxr, dyt, dyb;
  logic [MW-1:0]        mxl, mxr, myt, myb;
  logic [COORD_BITS-1:0] radius;
  hit_flags_t           flags;

  logic                 valid_q;
  logic [OP_BITS-1:0]   op_q;
  logic [MW-1:0]        mxl_q, mxr_q, myt_q, myb_q;
  logic [COORD_BITS-1:0] radius_q;
  hit_flags_t           flags_q;

  // Widen all fields so no sum or difference can wrap.
  assign x1 = EW'(first_x_i);
  assign y1 = EW'(first_y_i);
  assign x2 = EW'(second_x_i);
  assign y2 = EW'(second_y_i);
  assign w1 = signed'(EW'(first_width_i));
  assign h1 = signed'(EW'(first_height_i));
  assign r1 = signed'(EW'(first_radius_i));
  assign w2 = signed'(EW'(second_width_i));
  assign h2 = signed'(EW'(second_height_i));

  // Offsets from the first centre to the second box's edges (also the plain
  // centre-to-centre or centre-to-point distance on the left and top terms).
  assign dxl = x1 - x2;
  assign dxr = x1 - x2 - w2;
  assign dyt = y1 - y2;
  assign dyb = y1 - y2 - h2;

  assign mxl = MW'(dxl < 0 ? -dxl : dxl);
  assign mxr = MW'(dxr < 0 ? -dxr : dxr);
  assign myt = MW'(dyt < 0 ? -dyt : dyt);
  assign myb = MW'(dyb < 0 ? -dyb : dyb);

  // Circle-circle compares against the radius sum, the others against r1.
  assign radius = (op_i == OP_CIRCLE_CIRCLE)
                  ? COORD_BITS'({1'b0, first_radius_i} + {1'b0, second_radius_i})
                  : COORD_BITS'(first_radius_i);

  // Compare-only tests.
  always_comb begin
    flags.box_box = !(x2 >= x1 + w1 || x2 + w2 <= x1 || y2 >= y1 + h1 || y2 + h2 <= y1);
    flags.box_point = (x2 >= x1) && (x2 < x1 + w1) && (y2 >= y1) && (y2 < y1 + h1);
    flags.cb_pretest = !(x1 - r1 >= x2 + w2 || x1 + r1 <= x2 ||
                         y1 - r1 >= y2 + h2 || y1 + r1 <= y2);
    flags.cb_other = ((x1 >= x2) && (x1 < x2 + w2) && (y1 >= y2) && (y1 < y2 + h2)) ||
                     (h2 == 0) || ((y2 <= y1) && (y1 <= y2 + h2)) ||
                     (w2 == 0) || ((x2 <= x1) && (x1 <= x2 + w2));
  end

  assign ready_o = !valid_q || ready_i;

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload, loaded on every transfer in.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      op_q     <= op_i;
      mxl_q    <= mxl;
      mxr_q    <= mxr;
      myt_q    <= myt;
      myb_q    <= myb;
      radius_q <= radius;
      flags_q  <= flags;
    end
  end

  assign valid_o  = valid_q;
  assign op_o     = op_q;
  assign mag_xl_o = mxl_q;
  assign mag_xr_o = mxr_q;
  assign mag_yt_o = myt_q;
  assign mag_yb_o = myb_q;
  assign radius_o = radius_q;
  assign flags_o  = flags_q;
endmodule

// ----- hdl/spo_square.sv -----
module spo_square #(
  parameter int COORD_BITS = spo_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [spo_pkg::OP_BITS-1:0]   op_i,
  input  logic [COORD_BITS:0]           mag_xl_i,
  input  logic [COORD_BITS:0]           mag_xr_i,
  input  logic [COORD_BITS:0]           mag_yt_i,
  input  logic [COORD_BITS:0]           mag_yb_i,
  input  logic [COORD_BITS-1:0]         radius_i,
  input  spo_pkg::hit_flags_t           flags_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [spo_pkg::OP_BITS-1:0]   op_o,
  output logic [2*COORD_BITS+1:0]       sq_xl_o,
  output logic [2*COORD_BITS+1:0]       sq_xr_o,
  output logic [2*COORD_BITS+1:0]       sq_yt_o,
  output logic [2*COORD_BITS+1:0]       sq_yb_o,
  output logic [2*COORD_BITS-1:0]       sq_r_o,
  output spo_pkg::hit_flags_t           flags_o
);
  import spo_pkg::*;

  localparam int SW = 2 * COORD_BITS + 2;
  localparam int RW = 2 * COORD_BITS;

  logic               valid_q;
  logic [OP_BITS-1:0] op_q;
  logic [SW-1:0]      sq_xl_q, sq_xr_q, sq_yt_q, sq_yb_q;
  logic [RW-1:0]      sq_r_q;
  hit_flags_t         flags_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Five squarers, one register after each.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      op_q    <= op_i;
      sq_xl_q <= SW'(mag_xl_i) * SW'(mag_xl_i);
      sq_xr_q <= SW'(mag_xr_i) * SW'(mag_xr_i);
      sq_yt_q <= SW'(mag_yt_i) * SW'(mag_yt_i);
      sq_yb_q <= SW'(mag_yb_i) * SW'(mag_yb_i);
      sq_r_q  <= RW'(radius_i) * RW'(radius_i);
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign sq_xl_o = sq_xl_q;
  assign sq_xr_o = sq_xr_q;
  assign sq_yt_o = sq_yt_q;
  assign sq_yb_o = sq_yb_q;
  assign sq_r_o  = sq_r_q;
  assign flags_o = flags_q;
endmodule

// ----- hdl/spo_decide.sv -----
module spo_decide #(
  parameter int COORD_BITS = spo_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [spo_pkg::OP_BITS-1:0]   op_i,
  input  logic [2*COORD_BITS+1:0]       sq_xl_i,
  input  logic [2*COORD_BITS+1:0]       sq_xr_i,
  input  logic [2*COORD_BITS+1:0]       sq_yt_i,
  input  logic [2*COORD_BITS+1:0]       sq_yb_i,
  input  logic [2*COORD_BITS-1:0]       sq_r_i,
  input  spo_pkg::hit_flags_t           flags_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic                          overlapping_o
);
  import spo_pkg::*;

  localparam int DW = 2 * COORD_BITS + 3;

  logic [DW-1:0] d_lt, d_lb, d_rt, d_rb, r2;
  logic          corner_in, hit;
  logic          valid_q, hit_q;

  // Squared distances from the first centre to the box corners; the
  // left-top one doubles as the plain centre distance.
  assign d_lt = DW'(sq_xl_i) + DW'(sq_yt_i);
  assign d_lb = DW'(sq_xl_i) + DW'(sq_yb_i);
  assign d_rt = DW'(sq_xr_i) + DW'(sq_yt_i);
  assign d_rb = DW'(sq_xr_i) + DW'(sq_yb_i);
  assign r2   = DW'(sq_r_i);

  assign corner_in = (d_lt < r2) || (d_lb < r2) || (d_rt < r2) || (d_rb < r2);

  // Select the answer for the pair kind.
  always_comb begin
    unique case (op_i)
      OP_CIRCLE_CIRCLE: hit = (d_lt <= r2);
      OP_BOX_BOX:       hit = flags_i.box_box;
      OP_CIRCLE_BOX:    hit = flags_i.cb_pretest && (corner_in || flags_i.cb_other);
      OP_CIRCLE_POINT:  hit = (d_lt < r2);
      OP_BOX_POINT:     hit = flags_i.box_point;
      default:          hit = 1'b0;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Output register; holds while the result waits for its transfer.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hit_q <= hit;
    end
  end

  assign valid_o       = valid_q;
  assign overlapping_o = hit_q;
endmodule

// ----- hdl/shape_pair_overlap_test.sv -----
// Shape pair overlap test: one pair of shapes (circle-circle, box-box,
// circle-box, circle-point or box-point, chosen by op) goes in per transfer
// and one overlap bit comes out. The block takes a new pair in every cycle
// unless a stall holds it, and each pair passes through the pipeline in
// order: differences and all compare-only box tests, then the squarers,
// then the distance sums, the final compares and the output register.
// Each stage holds its item when the next one is full, so a stall at the
// output backs up stage by stage and no pair is lost or repeated. Coordinates
// are COORD_BITS wide and signed; sizes and radii are COORD_BITS-1 bits
// unsigned. Unused op codes give no overlap.
module shape_pair_overlap_test #(
  parameter int COORD_BITS = spo_pkg::COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spo_in_if.sink     in_i,
  spo_out_if.source  out_o
);
  import spo_pkg::*;

  localparam int SW = 2 * COORD_BITS + 2;

  // First stage to squarers.
  logic                  s1_valid, s1_ready;
  logic [OP_BITS-1:0]    s1_op;
  logic [COORD_BITS:0]   s1_mxl, s1_mxr, s1_myt, s1_myb;
  logic [COORD_BITS-1:0] s1_radius;
  hit_flags_t            s1_flags;

  // Squarers to decision stage.
  logic                  s2_valid, s2_ready;
  logic [OP_BITS-1:0]    s2_op;
  logic [SW-1:0]         s2_sxl, s2_sxr, s2_syt, s2_syb;
  logic [2*COORD_BITS-1:0] s2_sr;
  hit_flags_t            s2_flags;

  spo_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_i.valid),
    .ready_o         (in_i.ready),
    .op_i            (in_i.op),
    .first_x_i       (in_i.first_x),
    .first_y_i       (in_i.first_y),
    .first_width_i   (in_i.first_width),
    .first_height_i  (in_i.first_height),
    .first_radius_i  (in_i.first_radius),
    .second_x_i      (in_i.second_x),
    .second_y_i      (in_i.second_y),
    .second_width_i  (in_i.second_width),
    .second_height_i (in_i.second_height),
    .second_radius_i (in_i.second_radius),
    .valid_o         (s1_valid),
    .ready_i         (s1_ready),
    .op_o            (s1_op),
    .mag_xl_o        (s1_mxl),
    .mag_xr_o        (s1_mxr),
    .mag_yt_o        (s1_myt),
    .mag_yb_o        (s1_myb),
    .radius_o        (s1_radius),
    .flags_o         (s1_flags)
  );

  spo_square #(.COORD_BITS(COORD_BITS)) u_square (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .ready_o  (s1_ready),
    .op_i     (s1_op),
    .mag_xl_i (s1_mxl),
    .mag_xr_i (s1_mxr),
    .mag_yt_i (s1_myt),
    .mag_yb_i (s1_myb),
    .radius_i (s1_radius),
    .flags_i  (s1_flags),
    .valid_o  (s2_valid),
    .ready_i  (s2_ready),
    .op_o     (s2_op),
    .sq_xl_o  (s2_sxl),
    .sq_xr_o  (s2_sxr),
    .sq_yt_o  (s2_syt),
    .sq_yb_o  (s2_syb),
    .sq_r_o   (s2_sr),
    .flags_o  (s2_flags)
  );

  spo_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s2_valid),
    .ready_o       (s2_ready),
    .op_i          (s2_op),
    .sq_xl_i       (s2_sxl),
    .sq_xr_i       (s2_sxr),
    .sq_yt_i       (s2_syt),
    .sq_yb_i       (s2_syb),
    .sq_r_i        (s2_sr),
    .flags_i       (s2_flags),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .overlapping_o (out_o.overlapping)
  );

  // With the output stage empty the whole pipeline can move, so input is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input refused while the output stage is empty");

  // A pair taken in passes the prep, squarer and output registers in order and shows at the output when nothing stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, 3) && $past(in_i.valid && in_i.ready, 3) &&
    $past(out_o.ready, 1) && $past(out_o.ready, 2) |-> out_o.valid)
    else $error("result missing after three unstalled cycles");

  // Internal stage handshakes never drop an item while the next stage is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && !s2_valid |-> s1_ready)
    else $error("squarer stage refused an item while empty");
endmodule

// ----- test/testbench.sv -----
module testbench;
  import spo_pkg::*;

  localparam int CB        = COORD_BITS_DEF;
  localparam int COORD_MIN = -(2 ** (CB - 1));
  localparam int COORD_MAX = 2 ** (CB - 1) - 1;
  localparam int SIZE_MAX  = 2 ** (CB - 1) - 1;

  // Op codes that name no pair kind.
  localparam logic [OP_BITS-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_BITS-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_LAST  = 3'd7;

  // A directed row either carries its answer or leaves it to the predictor.
  localparam int WANT_PREDICT = -1;
  localparam int WANT_MISS    = 0;
  localparam int WANT_HIT     = 1;

  localparam int RANDOM_PAIRS = 1100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_MAX   = 10;
  localparam int IDLE_PERCENT = 16;

  typedef struct packed {
    logic [OP_BITS-1:0]  op;
    logic signed [CB-1:0] fx;
    logic signed [CB-1:0] fy;
    logic [CB-2:0]        fw;
    logic [CB-2:0]        fh;
    logic [CB-2:0]        fr;
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic [CB-2:0]        sw;
    logic [CB-2:0]        sh;
    logic [CB-2:0]        sr;
  } pair_t;

  typedef struct {
    pair_t pair;
    int    want;
  } row_t;

  typedef struct {
    logic [OP_BITS-1:0] op;
    bit                 hit;
    int                 seq;
  } overlap_exp_t;

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int   mismatches;
  int   cycles;
  int   accepted;

  overlap_exp_t overlap_q[$];
  row_t         directed[$];

  spo_in_if #(.COORD_BITS(CB)) in_if ();
  spo_out_if                   out_if ();

  shape_pair_overlap_test #(.COORD_BITS(CB)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock with a period of 20.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Half-open boxes [l, l+w) by [t, t+h) overlap strictly on both axes.
  function automatic bit boxes_meet(longint l1, longint t1, longint w1, longint h1,
                                    longint l2, longint t2, longint w2, longint h2);
    return !(l2 >= l1 + w1 || l2 + w2 <= l1 || t2 >= t1 + h1 || t2 + h2 <= t1);
  endfunction

  function automatic bit point_in_disc(longint cx, longint cy, longint r,
                                       longint px, longint py);
    return (px - cx) * (px - cx) + (py - cy) * (py - cy) < r * r;
  endfunction

  function automatic bit point_in_rect(longint l, longint t, longint w, longint h,
                                       longint px, longint py);
    return px >= l && px < l + w && py >= t && py < t + h;
  endfunction

  // Overlap of one pair, worked out in 64-bit arithmetic so nothing wraps.
  function automatic bit overlap_of(pair_t p);
    longint x1, y1, w1, h1, r1, x2, y2, w2, h2, r2, rs;
    bit hit;
    x1 = longint'($signed(p.fx));
    y1 = longint'($signed(p.fy));
    w1 = longint'(p.fw);
    h1 = longint'(p.fh);
    r1 = longint'(p.fr);
    x2 = longint'($signed(p.sx));
    y2 = longint'($signed(p.sy));
    w2 = longint'(p.sw);
    h2 = longint'(p.sh);
    r2 = longint'(p.sr);
    hit = 1'b0;
    case (p.op)
      OP_CIRCLE_CIRCLE: begin
        rs = r1 + r2;
        hit = (x1 - x2) * (x1 - x2) + (y1 - y2) * (y1 - y2) <= rs * rs;
      end
      OP_BOX_BOX: begin
        hit = boxes_meet(x1, y1, w1, h1, x2, y2, w2, h2);
      end
      OP_CIRCLE_BOX: begin
        // Bounding-box pretest first, then corners, containment and edge spans.
        if (boxes_meet(x2, y2, w2, h2, x1 - r1, y1 - r1, 2 * r1, 2 * r1)) begin
          hit = point_in_disc(x1, y1, r1, x2, y2)
             || point_in_disc(x1, y1, r1, x2, y2 + h2)
             || point_in_disc(x1, y1, r1, x2 + w2, y2)
             || point_in_disc(x1, y1, r1, x2 + w2, y2 + h2)
             || point_in_rect(x2, y2, w2, h2, x1, y1)
             || h2 == 0 || (y2 <= y1 && y1 <= y2 + h2)
             || w2 == 0 || (x2 <= x1 && x1 <= x2 + w2);
        end
      end
      OP_CIRCLE_POINT: begin
        hit = point_in_disc(x1, y1, r1, x2, y2);
      end
      OP_BOX_POINT: begin
        hit = point_in_rect(x1, y1, w1, h1, x2, y2);
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  function automatic row_t mk(logic [OP_BITS-1:0] op, int fx, int fy, int fw, int fh,
                              int fr, int sx, int sy, int sw, int sh, int sr, int want);
    row_t row;
    row.pair.op = op;
    row.pair.fx = CB'(fx);
    row.pair.fy = CB'(fy);
    row.pair.fw = (CB-1)'(fw);
    row.pair.fh = (CB-1)'(fh);
    row.pair.fr = (CB-1)'(fr);
    row.pair.sx = CB'(sx);
    row.pair.sy = CB'(sy);
    row.pair.sw = (CB-1)'(sw);
    row.pair.sh = (CB-1)'(sh);
    row.pair.sr = (CB-1)'(sr);
    row.want    = want;
    return row;
  endfunction

  function automatic longint jitter(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly shapes clustered around a common spot so that hits are frequent,
  // with some pairs over the full range and the odd extreme value.
  function automatic pair_t random_pair();
    pair_t  p;
    int     span;
    longint bx, by;
    if ($urandom_range(0, 99) < 94)
      p.op = OP_BITS'($urandom_range(OP_CIRCLE_CIRCLE, OP_BOX_POINT));
    else
      p.op = OP_BITS'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    case ($urandom_range(0, 3))
      0:       span = 0;
      1:       span = 16;
      2:       span = 64;
      default: span = 2048;
    endcase
    if (span == 0) begin
      p.fx = CB'($urandom());
      p.fy = CB'($urandom());
      p.fw = (CB-1)'($urandom());
      p.fh = (CB-1)'($urandom());
      p.fr = (CB-1)'($urandom());
      p.sx = CB'($urandom());
      p.sy = CB'($urandom());
      p.sw = (CB-1)'($urandom());
      p.sh = (CB-1)'($urandom());
      p.sr = (CB-1)'($urandom());
    end else begin
      bx = longint'($urandom_range(0, 60000)) - 30000;
      by = longint'($urandom_range(0, 60000)) - 30000;
      p.fx = CB'(bx + jitter(span));
      p.fy = CB'(by + jitter(span));
      p.sx = CB'(bx + jitter(span));
      p.sy = CB'(by + jitter(span));
      p.fw = (CB-1)'($urandom_range(0, span));
      p.fh = (CB-1)'($urandom_range(0, span));
      p.fr = (CB-1)'($urandom_range(0, span));
      p.sw = (CB-1)'($urandom_range(0, span));
      p.sh = (CB-1)'($urandom_range(0, span));
      p.sr = (CB-1)'($urandom_range(0, span));
    end
    if ($urandom_range(0, 19) == 0) begin
      p.fx = $urandom_range(0, 1) ? CB'(COORD_MAX) : CB'(COORD_MIN);
      p.sy = $urandom_range(0, 1) ? CB'(COORD_MAX) : CB'(COORD_MIN);
      p.fr = $urandom_range(0, 1) ? (CB-1)'(SIZE_MAX) : '0;
      p.sw = $urandom_range(0, 1) ? (CB-1)'(SIZE_MAX) : '0;
    end
    return p;
  endfunction

  // One transfer on the input side, with random idle cycles in front of it.
  task automatic transfer(pair_t p, int want);
    overlap_exp_t e;
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.op            <= p.op;
    in_if.first_x       <= p.fx;
    in_if.first_y       <= p.fy;
    in_if.first_width   <= p.fw;
    in_if.first_height  <= p.fh;
    in_if.first_radius  <= p.fr;
    in_if.second_x      <= p.sx;
    in_if.second_y      <= p.sy;
    in_if.second_width  <= p.sw;
    in_if.second_height <= p.sh;
    in_if.second_radius <= p.sr;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    e.op  = p.op;
    e.hit = (want == WANT_PREDICT) ? overlap_of(p) : want[0];
    e.seq = accepted;
    accepted++;
    overlap_q = {overlap_q, e};
  endtask

  // Output side stalls at random, except during the steady stretch.
  always @(posedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    overlap_exp_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (overlap_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: overlapping=%b", out_if.overlapping);
      end else begin
        e = overlap_q.pop_front();
        if (out_if.overlapping !== e.hit) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("pair %0d op %0d: expected overlapping=%b, got %b",
                     e.seq, e.op, e.hit, out_if.overlapping);
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL shape_pair_overlap_test");
      $finish;
    end
  end

  initial begin
    accepted   = 0;
    steady     = 1'b0;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.op            <= OP_CIRCLE_CIRCLE;
    in_if.first_x       <= '0;
    in_if.first_y       <= '0;
    in_if.first_width   <= '0;
    in_if.first_height  <= '0;
    in_if.first_radius  <= '0;
    in_if.second_x      <= '0;
    in_if.second_y      <= '0;
    in_if.second_width  <= '0;
    in_if.second_height <= '0;
    in_if.second_radius <= '0;

    // Directed pairs: unused codes, touching and extreme shapes, every kind.
    directed = '{
      mk(OP_SPARE_FIRST, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX,
         COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX, WANT_MISS),
      mk(OP_SPARE_MID, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, SIZE_MAX,
         COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, SIZE_MAX, WANT_MISS),
      mk(OP_SPARE_LAST, 0, 0, 10, 10, 10, 0, 0, 10, 10, 10, WANT_MISS),
      mk(OP_CIRCLE_CIRCLE, 0, 0, 0, 0, 3, 5, 0, 0, 0, 2, WANT_HIT),
      mk(OP_CIRCLE_CIRCLE, 0, 0, 0, 0, 3, 6, 0, 0, 0, 2, WANT_MISS),
      mk(OP_CIRCLE_CIRCLE, 7, -7, 0, 0, 0, 7, -7, 0, 0, 0, WANT_HIT),
      mk(OP_CIRCLE_CIRCLE, COORD_MIN, COORD_MIN, 0, 0, SIZE_MAX,
         COORD_MAX, COORD_MAX, 0, 0, SIZE_MAX, WANT_MISS),
      mk(OP_CIRCLE_CIRCLE, COORD_MIN, 0, 0, 0, SIZE_MAX,
         COORD_MAX, 0, 0, 0, SIZE_MAX, WANT_PREDICT),
      mk(OP_BOX_BOX, 0, 0, 10, 10, 0, 10, 0, 10, 10, 0, WANT_MISS),
      mk(OP_BOX_BOX, 0, 0, 10, 10, 0, 9, 9, 10, 10, 0, WANT_HIT),
      mk(OP_BOX_BOX, 0, 0, 0, 10, 0, -5, 0, 10, 10, 0, WANT_PREDICT),
      mk(OP_BOX_BOX, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, 0,
         COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, 0, WANT_MISS),
      mk(OP_CIRCLE_BOX, 0, 0, 0, 0, 10, 20, 20, 5, 5, 0, WANT_MISS),
      mk(OP_CIRCLE_BOX, 0, 0, 0, 0, 10, 8, 8, 0, 0, 0, WANT_PREDICT),
      mk(OP_CIRCLE_BOX, 0, 0, 0, 0, 10, 5, 5, 100, 100, 0, WANT_PREDICT),
      mk(OP_CIRCLE_BOX, 0, 0, 0, 0, 10, 8, 8, 10, 10, 0, WANT_PREDICT),
      mk(OP_CIRCLE_BOX, 0, 0, 0, 0, 10, -20, 8, 40, 5, 0, WANT_PREDICT),
      mk(OP_CIRCLE_BOX, 0, 0, 0, 0, 10, 8, -20, 5, 40, 0, WANT_PREDICT),
      mk(OP_CIRCLE_BOX, 0, 0, 0, 0, 1, -100, -100, 200, 200, 0, WANT_PREDICT),
      mk(OP_CIRCLE_BOX, 5, 5, 0, 0, 0, 0, 0, 10, 10, 0, WANT_PREDICT),
      mk(OP_CIRCLE_BOX, COORD_MAX, COORD_MAX, 0, 0, SIZE_MAX,
         COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, 0, WANT_PREDICT),
      mk(OP_CIRCLE_POINT, 0, 0, 0, 0, 5, 3, 4, 0, 0, 0, WANT_MISS),
      mk(OP_CIRCLE_POINT, 0, 0, 0, 0, 5, 3, 3, 0, 0, 0, WANT_HIT),
      mk(OP_CIRCLE_POINT, 4, 4, 0, 0, 0, 4, 4, 0, 0, 0, WANT_MISS),
      mk(OP_CIRCLE_POINT, COORD_MIN, COORD_MIN, 0, 0, SIZE_MAX,
         COORD_MAX, COORD_MAX, 0, 0, 0, WANT_MISS),
      mk(OP_BOX_POINT, 0, 0, 10, 10, 0, 0, 0, 0, 0, 0, WANT_HIT),
      mk(OP_BOX_POINT, 0, 0, 10, 10, 0, 10, 5, 0, 0, 0, WANT_MISS),
      mk(OP_BOX_POINT, 0, 0, 0, 10, 0, 0, 0, 0, 0, 0, WANT_MISS)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) transfer(directed[i].pair, directed[i].want);

    // Random pairs, with a stretch in the middle where neither side idles.
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      steady = (n >= 400 && n < 600);
      transfer(random_pair(), WANT_PREDICT);
    end
    steady = 1'b0;
    in_if.valid <= 1'b0;

    // Drain the pipeline, then keep watching the output for anything stray.
    while (overlap_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0)
      $display("PASS shape_pair_overlap_test");
    else
      $display("FAIL shape_pair_overlap_test");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/spo_pkg.sv
hdl/spo_in_if.sv
hdl/spo_out_if.sv
hdl/spo_prep.sv
hdl/spo_square.sv
hdl/spo_decide.sv
hdl/shape_pair_overlap_test.sv
test/testbench.sv
